// ===== sv/digit_trie_prefix_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// digit trie prefix table assertion macros
// shared assertion forms for the checker, clocked on clk, held off by rst_n
// ----------------------------------------------------------------------------
`ifndef DIGIT_TRIE_PREFIX_TABLE_CORE_MACROS_SVH
`define DIGIT_TRIE_PREFIX_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define DTP_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// shared constants for the digit trie prefix table
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  localparam int NODES_DEF    = 4096;
  localparam int ALPHABET_DEF = 10;

  localparam int OP_W        = 2;
  localparam int DIGIT_W     = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/dtp_ram.sv =====
// ----------------------------------------------------------------------------
// dtp_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_ram
  import dtp_pkg::*;
#(
  parameter int   DEPTH = NODES_DEF,
  parameter int   WIDTH = 8,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/digit_trie_prefix_table_core.sv =====
// ----------------------------------------------------------------------------
// digit_trie_prefix_table_core
// digit trie kept in a child table and a node table, walked one digit a word
// ----------------------------------------------------------------------------
// input words carry op and digit in in_tdata, in_tlast marks the final digit
// of a string. ops: insert, exact query, proper-prefix check, clear.
// one result word per input word with in_tlast set; out_tdata bit 0 is
// found, bit 1 is full (insert ran out of nodes).
// a digit word goes through a child table read, a node table read of the
// child, then decide and write back. in_tready is low in between.
// a clear word is handled in the cycle it is taken. the result is in the
// output register after the last digit's decide step (at once for clear).
// the output register frees the input side: a new word is taken in the
// cycle the pending result is taken. while the receiver stalls with a
// result held, in_tready stays low.
// after reset the child table is zeroed, one entry a cycle, all
// NODES*ALPHABET entries (40960 by default), with in_tready low.
// child entries are validated against the parent slot stored per node,
// so neither clear nor node allocation needs to sweep a row.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_trie_prefix_table_core
  import dtp_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // op [1:0], digit [5:2], zero pad
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // found [0], full_res [1], zero pad
);

  localparam int NW       = $clog2(NODES);
  localparam int CH_DEPTH = NODES * ALPHABET;
  localparam int CW       = $clog2(CH_DEPTH);
  localparam int ND_W     = CW + 1;

  localparam logic [NW:0]   NODES_CNT  = (NW+1)'(NODES);
  localparam logic [CW-1:0] SWEEP_LAST = CW'(CH_DEPTH - 1);
  localparam logic [CW-1:0] ALPHA_C    = CW'(ALPHABET);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHILD = 2'd2;
  localparam logic [1:0] ST_NODE  = 2'd3;

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [NW:0]   used_r, used_nxt;
  logic [NW-1:0] walk_r, walk_nxt;
  logic          walk_mark_r, walk_mark_nxt;
  logic          pfx_hit_r, pfx_hit_nxt;
  logic          failed_r, failed_nxt;
  logic          lost_r, lost_nxt;
  logic          skip_r, skip_nxt;
  logic          out_valid_r, out_valid_nxt;

  // item payload
  logic [OP_W-1:0] op_r, op_nxt;
  logic            last_r, last_nxt;
  logic [CW-1:0]   slot_r, slot_nxt;
  logic            out_found_r, out_found_nxt;
  logic            out_full_r, out_full_nxt;

  logic [OP_W-1:0]    in_op;
  logic [DIGIT_W-1:0] in_digit;
  logic               accept;
  logic               digit_ok;
  logic [CW-1:0]      slot_calc;

  logic            ch_we;
  logic [CW-1:0]   ch_waddr;
  logic [NW-1:0]   ch_wdata;
  logic [NW-1:0]   ch_rdata;
  logic            nd_we;
  logic [NW-1:0]   nd_waddr;
  logic [ND_W-1:0] nd_wdata;
  logic [ND_W-1:0] nd_rdata;

  logic [CW-1:0] nd_par;
  logic          nd_mark;
  logic          edge_hit;
  logic          room;

  assign in_op    = in_tdata[1:0];
  assign in_digit = in_tdata[5:2];
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign digit_ok  = 32'(in_digit) < ALPHABET;
  assign slot_calc = CW'(walk_r) * ALPHA_C + CW'(in_digit);

  // child entry is real only if that node was allocated from this slot
  assign nd_par   = nd_rdata[ND_W-1:1];
  assign nd_mark  = nd_rdata[0];
  assign edge_hit = (ch_rdata != '0) && ({1'b0, ch_rdata} < used_r) && (nd_par == slot_r);
  assign room     = used_r < NODES_CNT;

  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    used_nxt      = used_r;
    walk_nxt      = walk_r;
    walk_mark_nxt = walk_mark_r;
    pfx_hit_nxt   = pfx_hit_r;
    failed_nxt    = failed_r;
    lost_nxt      = lost_r;
    skip_nxt      = skip_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && !out_tready;

    ch_we    = 1'b0;
    ch_waddr = slot_r;
    ch_wdata = used_r[NW-1:0];
    nd_we    = 1'b0;
    nd_waddr = used_r[NW-1:0];
    nd_wdata = {slot_r, last_r};

    case (state_r)
      ST_SWEEP: begin
        ch_we         = 1'b1;
        ch_waddr      = sweep_cnt_r;
        ch_wdata      = '0;
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == SWEEP_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_CLEAR) begin
            used_nxt      = (NW+1)'(1);
            walk_nxt      = '0;
            walk_mark_nxt = 1'b0;
            pfx_hit_nxt   = 1'b0;
            failed_nxt    = 1'b0;
            lost_nxt      = 1'b0;
            if (in_tlast) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              out_full_nxt  = 1'b0;
            end
          end else begin
            op_nxt    = in_op;
            last_nxt  = in_tlast;
            slot_nxt  = slot_calc;
            lost_nxt  = lost_r || !digit_ok;
            skip_nxt  = lost_r || failed_r || !digit_ok;
            state_nxt = ST_CHILD;
          end
        end
      end
      ST_CHILD: begin
        state_nxt = ST_NODE;
      end
      ST_NODE: begin
        state_nxt = ST_IDLE;
        if (!skip_r) begin
          if (op_r == OP_INSERT) begin
            if (edge_hit) begin
              walk_nxt      = ch_rdata;
              walk_mark_nxt = nd_mark;
              // end of string on an existing node: set its mark
              nd_we    = last_r;
              nd_waddr = ch_rdata;
            end else if (room) begin
              ch_we         = 1'b1;
              nd_we         = 1'b1;
              used_nxt      = used_r + 1'b1;
              walk_nxt      = used_r[NW-1:0];
              walk_mark_nxt = last_r;
            end else begin
              failed_nxt = 1'b1;
            end
          end else if (!edge_hit) begin
            lost_nxt = 1'b1;
          end else begin
            walk_nxt      = ch_rdata;
            walk_mark_nxt = nd_mark;
            if (op_r == OP_PREFIX && nd_mark && !last_r) begin
              pfx_hit_nxt = 1'b1;
            end
          end
        end
        if (last_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_full_nxt  = 1'b0;
          case (op_r)
            OP_INSERT: out_full_nxt  = failed_nxt;
            OP_QUERY:  out_found_nxt = !lost_nxt && walk_mark_nxt;
            default:   out_found_nxt = pfx_hit_nxt;
          endcase
          walk_nxt      = '0;
          walk_mark_nxt = 1'b0;
          pfx_hit_nxt   = 1'b0;
          failed_nxt    = 1'b0;
          lost_nxt      = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
      used_r      <= (NW+1)'(1);
      walk_r      <= '0;
      walk_mark_r <= 1'b0;
      pfx_hit_r   <= 1'b0;
      failed_r    <= 1'b0;
      lost_r      <= 1'b0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      used_r      <= used_nxt;
      walk_r      <= walk_nxt;
      walk_mark_r <= walk_mark_nxt;
      pfx_hit_r   <= pfx_hit_nxt;
      failed_r    <= failed_nxt;
      lost_r      <= lost_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    slot_r      <= slot_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

  // child table: node index per (node, digit), zero means no edge
  dtp_ram #(
    .DEPTH (CH_DEPTH),
    .WIDTH (NW)
  ) u_child_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (accept),
    .raddr (slot_calc),
    .rdata (ch_rdata)
  );

  // node table: parent slot and word end mark per node
  dtp_ram #(
    .DEPTH (NODES),
    .WIDTH (ND_W)
  ) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .re    (state_r == ST_CHILD),
    .raddr (ch_rdata),
    .rdata (nd_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_full_r, out_found_r};

endmodule

`default_nettype wire

// ===== sv/dtp_checker.sv =====
// ----------------------------------------------------------------------------
// dtp_checker
// port-level checks for the digit trie prefix table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "digit_trie_prefix_table_core_macros.svh"

module dtp_checker
  import dtp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   in_tlast,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  `DTP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // a taken digit word drops in_tready while it is walked
  `DTP_ASSERT_NEXT(a_digit_busy, in_tvalid && in_tready && (in_tdata[1:0] != OP_CLEAR), !in_tready, "word taken while a digit was in flight")

  `DTP_ASSERT_NEXT(a_clear_result, in_tvalid && in_tready && (in_tdata[1:0] == OP_CLEAR) && in_tlast, out_tvalid && (out_tdata[1:0] == 2'b00), "clear did not answer with an empty result")

  // found and full come from different ops
  `DTP_ASSERT_IMPLY(a_out_fields, out_tvalid, (out_tdata[7:2] == 6'd0) && !(out_tdata[0] && out_tdata[1]), "bad result word")

endmodule

bind digit_trie_prefix_table_core dtp_checker u_dtp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
